>>> rtl/bs_pkg.sv
// Shared types and constants for the bitonic sorter.
package bs_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 3;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd6;

  // APB register map
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int IDX_W  = 1;
  localparam logic [IDX_W-1:0] REG_SIZE_LOG2 = 1'd0;

  // write data source for the value store
  typedef enum logic [1:0] {
    WSEL_LOAD   = 2'd0,
    WSEL_FIRST  = 2'd1,
    WSEL_SECOND = 2'd2
  } wr_sel_e;

  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    dir_desc;
    logic    out_load;
  } bs_cmd_t;

endpackage

>>> rtl/bs_in_if.sv
// Input channel: one unsorted value per beat.
interface bs_in_if import bs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

>>> rtl/bs_out_if.sv
// Output channel: one sorted value per beat, last marks the end of a run.
interface bs_out_if import bs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last;

  modport source (output valid, output sorted_value, output last, input ready);
  modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

>>> rtl/bs_datapath.sv
// Value store, compare-exchange unit and output payload register.
module bs_datapath import bs_pkg::*; #(
  parameter int MAX_LOG2 = 6
) (
  input  logic                     clk_i,
  input  bs_cmd_t                  cmd_i,
  input  logic [MAX_LOG2-1:0]      rd_a_addr_i,
  input  logic [MAX_LOG2-1:0]      rd_b_addr_i,
  input  logic [MAX_LOG2-1:0]      wr_addr_i,
  input  logic signed [DATA_W-1:0] in_value_i,
  output logic signed [DATA_W-1:0] sorted_value_o
);

  localparam int DEPTH = 1 << MAX_LOG2;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q, hold_q, out_q;
  logic signed [DATA_W-1:0] first, second, wdata;
  logic                     swap;

  // swap when the pair's order disagrees with the block direction
  always_comb begin
    swap   = ((rd_a_q > rd_b_q) == !cmd_i.dir_desc);
    first  = swap ? rd_b_q : rd_a_q;
    second = swap ? rd_a_q : rd_b_q;
    case (cmd_i.wr_sel)
      WSEL_LOAD:   wdata = in_value_i;
      WSEL_FIRST:  wdata = first;
      WSEL_SECOND: wdata = hold_q;
      default:     wdata = in_value_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr_i] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rd_a_q <= mem_q[rd_a_addr_i];
      rd_b_q <= mem_q[rd_b_addr_i];
    end
    if (cmd_i.wr_en && (cmd_i.wr_sel == WSEL_FIRST)) begin
      hold_q <= second;
    end
    if (cmd_i.out_load) begin
      out_q <= rd_a_q;
    end
  end

  assign sorted_value_o = out_q;

endmodule

>>> rtl/bs_ctrl.sv
// Sequencer: load counting, network stage/pass/pair walk, output draining.
module bs_ctrl import bs_pkg::*; #(
  parameter int MAX_LOG2 = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SIZE_W-1:0]   size_log2_i,
  input  logic                cfg_clear_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic                out_last_o,
  output bs_cmd_t             cmd_o,
  output logic [MAX_LOG2-1:0] rd_a_addr_o,
  output logic [MAX_LOG2-1:0] rd_b_addr_o,
  output logic [MAX_LOG2-1:0] wr_addr_o
);

  localparam int AW = MAX_LOG2;
  localparam int SW = $clog2(MAX_LOG2 + 1);

  typedef enum logic [6:0] {
    ST_LOAD     = 7'b0000001,
    ST_CX_RD    = 7'b0000010,
    ST_CX_WR1   = 7'b0000100,
    ST_CX_WR2   = 7'b0001000,
    ST_OUT_RD   = 7'b0010000,
    ST_OUT_CAP  = 7'b0100000,
    ST_OUT_HOLD = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic [SW-1:0]   s_q, s_d, p_q, p_d, k;
  logic [AW-1:0]   m_q, m_d, oidx_q, oidx_d;
  logic            out_valid_q, out_valid_d, last_q, last_d;
  logic [AW:0]     n, n_m1, half_m1;
  logic [AW-1:0]   pair_dist, mask, pair_i, pair_j;
  logic [AW:0]     iext;

  assign k       = (size_log2_i > SIZE_W'(MAX_LOG2)) ? SW'(MAX_LOG2) : SW'(size_log2_i);
  assign n       = (AW+1)'(1) << k;
  assign n_m1    = n - (AW+1)'(1);
  assign half_m1 = (n >> 1) - (AW+1)'(1);

  // pair index m -> (i, i+d): insert a zero at bit p
  assign pair_dist = AW'(1) << p_q;
  assign mask      = pair_dist - AW'(1);
  assign pair_i    = ((m_q << 1) & ~(mask | pair_dist)) | (m_q & mask);
  assign pair_j    = pair_i | pair_dist;
  assign iext      = {1'b0, pair_i};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    s_d         = s_q;
    p_d         = p_q;
    m_d         = m_q;
    oidx_d      = oidx_q;
    out_valid_d = out_valid_q;
    last_d      = last_q;
    cmd_o          = '0;
    cmd_o.wr_sel   = WSEL_LOAD;
    cmd_o.dir_desc = iext[s_q];
    rd_a_addr_o = pair_i;
    rd_b_addr_o = pair_j;
    wr_addr_o   = pair_j;

    unique case (state_q)
      ST_LOAD: begin
        wr_addr_o = cnt_q[AW-1:0];
        if (in_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (cnt_q == n_m1) begin
            cnt_d   = '0;
            s_d     = SW'(1);
            p_d     = '0;
            m_d     = '0;
            oidx_d  = '0;
            state_d = (k == '0) ? ST_OUT_RD : ST_CX_RD;
          end else begin
            cnt_d = cnt_q + (AW+1)'(1);
          end
        end
        if (cfg_clear_i) begin
          cnt_d = '0;
        end
      end
      ST_CX_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_CX_WR1;
      end
      ST_CX_WR1: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WSEL_FIRST;
        wr_addr_o    = pair_i;
        state_d      = ST_CX_WR2;
      end
      ST_CX_WR2: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WSEL_SECOND;
        state_d      = ST_CX_RD;
        if (m_q == half_m1[AW-1:0]) begin
          m_d = '0;
          if (p_q == '0) begin
            if (s_q == k) begin
              state_d = ST_OUT_RD;
            end else begin
              s_d = s_q + SW'(1);
              p_d = s_q;
            end
          end else begin
            p_d = p_q - SW'(1);
          end
        end else begin
          m_d = m_q + AW'(1);
        end
      end
      ST_OUT_RD: begin
        cmd_o.rd_en = 1'b1;
        rd_a_addr_o = oidx_q;
        rd_b_addr_o = oidx_q;
        state_d     = ST_OUT_CAP;
      end
      ST_OUT_CAP: begin
        cmd_o.out_load = 1'b1;
        out_valid_d    = 1'b1;
        last_d         = (oidx_q == n_m1[AW-1:0]);
        state_d        = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (out_ready_i) begin
          out_valid_d = 1'b0;
          if (last_q) begin
            state_d = ST_LOAD;
          end else begin
            oidx_d  = oidx_q + AW'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_LOAD;
      cnt_q       <= '0;
      s_q         <= '0;
      p_q         <= '0;
      m_q         <= '0;
      oidx_q      <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      s_q         <= s_d;
      p_q         <= p_d;
      m_q         <= m_d;
      oidx_q      <= oidx_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_last_o  = last_q;

`ifndef SYNTHESIS
  a_no_load_while_draining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while an output beat is pending");

  a_pair_in_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CX_RD) |-> ({1'b0, pair_j} < n))
    else $error("compare-exchange pair outside the batch");

  a_last_returns_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ready_i && last_q) |=> (state_q == ST_LOAD && cnt_q == '0))
    else $error("no clean restart after the last beat");

  a_count_below_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> (cnt_q < n))
    else $error("load count reached the batch size");
`endif

endmodule

>>> rtl/bitonic_sorter.sv
// Bitonic sorter top level: APB register, controller and datapath.
//
// Collects a batch of 2^k signed 32-bit values, one per input beat, where
// k = min(size_log2, MAX_LOG2). After the final value of the batch is taken
// the block runs a bitonic network over the single-port-write value store
// and then streams the batch out in ascending order, last set on the final
// beat. No input is taken from the last load beat until the last output
// beat is accepted. For a batch of n = 2^k values the block first loads n
// beats, then does each compare-exchange in turn (read both, write low,
// write high) over k(k+1)/2 passes of n/2 pairs, then reads, captures and
// hands off each output beat; the single store write port sets the
// compare-exchange cost. size_log2 sits at byte address 0 (reset 6; values
// above MAX_LOG2 act as MAX_LOG2); writing it restarts the batch count and
// is only allowed while the block waits for input. The store has no reset.
module bitonic_sorter import bs_pkg::*; #(
  parameter int MAX_LOG2 = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  bs_in_if.sink             in_i,
  bs_out_if.source          out_o
);

  logic [SIZE_W-1:0]   size_log2_q, size_log2_d;
  logic                cfg_we;
  logic [IDX_W-1:0]    reg_idx;
  bs_cmd_t             cmd;
  logic [MAX_LOG2-1:0] rd_a_addr, rd_b_addr, wr_addr;

  // register index is the word address
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == REG_SIZE_LOG2);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == REG_SIZE_LOG2) ? APB_DW'(size_log2_q) : '0;

  assign size_log2_d = cfg_we ? pwdata[SIZE_W-1:0] : size_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SIZE_RESET;
    end else begin
      size_log2_q <= size_log2_d;
    end
  end

  bs_ctrl #(
    .MAX_LOG2 (MAX_LOG2)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .size_log2_i (size_log2_q),
    .cfg_clear_i (cfg_we),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_last_o  (out_o.last),
    .cmd_o       (cmd),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr),
    .wr_addr_o   (wr_addr)
  );

  bs_datapath #(
    .MAX_LOG2 (MAX_LOG2)
  ) u_datapath (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .rd_a_addr_i    (rd_a_addr),
    .rd_b_addr_i    (rd_b_addr),
    .wr_addr_i      (wr_addr),
    .in_value_i     (in_i.value),
    .sorted_value_o (out_o.sorted_value)
  );

endmodule

>>> tb/sv/tb_bitonic_sorter.sv
`timescale 1ns / 100ps
// Self-checking testbench for bitonic_sorter: APB sizing, random input beats, sorted-run check.
module tb_bitonic_sorter;
  import bs_pkg::*;

  localparam int SORT_MAX_LOG2 = 6;
  localparam int STORE_N       = 1 << SORT_MAX_LOG2;

  // A 64-value batch spends its whole network phase with no beat moving,
  // so the quiet-cycle limit has to cover that phase with room to spare.
  localparam int STALL_LIMIT  = 10000;
  localparam int IDLE_CYCLES  = 12;   // settle time before a register access
  localparam int DRAIN_CYCLES = 60;   // watch for stray beats at the end
  localparam int RAND_ITEMS   = 80;

  localparam logic [APB_AW-1:0] ADDR_SIZE_LOG2 = APB_AW'(4 * REG_SIZE_LOG2);
  localparam logic [APB_AW-1:0] ADDR_UNMAPPED  = APB_AW'(4 * (REG_SIZE_LOG2 + 1));

  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last;
  } sorted_beat_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bs_in_if  in_if ();
  bs_out_if out_if ();

  bitonic_sorter #(
    .MAX_LOG2(SORT_MAX_LOG2)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predictor state: our own copy of the size register, the fill count of the
  // batch being loaded, and the batch itself.
  logic [SIZE_W-1:0]        size_cfg;
  int unsigned              fill_cnt;
  logic signed [DATA_W-1:0] batch_mem [STORE_N];

  logic signed [DATA_W-1:0] pend_q [$];    // values still to be sent
  sorted_beat_t             sorted_q [$];  // sorted beats owed by the block
  int unsigned              miss_cnt = 0;
  int unsigned              quiet_cnt = 0;
  int unsigned              src_gap;
  int unsigned              snk_gap;
  bit                       calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Bitonic network over the first 2^k entries of the batch. Stage s builds
  // runs of 2^s; within a stage the pair distance halves down to 1. The run
  // direction comes from bit s of the lower index. Swapping equal values
  // changes nothing, so ties need no special handling.
  function automatic void merge_network(input int unsigned k);
    int unsigned              n;
    int unsigned              d;
    int unsigned              j;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    bit                       up;
    n = 1 << k;
    for (int s = 1; s <= k; s++) begin
      for (int p = s - 1; p >= 0; p--) begin
        d = 1 << p;
        for (int unsigned i = 0; i < n; i++) begin
          if ((i & d) == 0) begin
            j  = i + d;
            up = ((i >> s) & 1) == 0;
            lo = batch_mem[i];
            hi = batch_mem[j];
            if ((lo > hi) == up) begin
              batch_mem[i] = hi;
              batch_mem[j] = lo;
            end
          end
        end
      end
    end
  endfunction

  // One accepted input beat: store it, and when the batch is full queue the
  // whole sorted run. Sizes above the maximum act as the maximum.
  function automatic void take_value(input logic signed [DATA_W-1:0] v);
    int unsigned  k;
    int unsigned  n;
    sorted_beat_t beat;
    k = (size_cfg > SORT_MAX_LOG2) ? SORT_MAX_LOG2 : size_cfg;
    n = 1 << k;
    batch_mem[fill_cnt] = v;
    fill_cnt++;
    if (fill_cnt == n) begin
      fill_cnt = 0;
      merge_network(k);
      for (int unsigned i = 0; i < n; i++) begin
        beat.sorted_value = batch_mem[i];
        beat.last         = (i == n - 1);
        sorted_q.push_back(beat);
      end
    end
  endfunction

  // Mix of extremes, a narrow band around zero (plenty of ties), and full range.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: begin
        return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      end
      1, 2: begin
        return $signed($urandom_range(0, 6)) - 3;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Input driver: presents the next pending value once the slot is free,
  // with random bursts of idle cycles between beats.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.value <= '0;
      src_gap     <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (src_gap != 0) begin
        in_if.valid <= 1'b0;
        src_gap     <= src_gap - 1;
      end else if (pend_q.size() != 0) begin
        in_if.valid <= 1'b1;
        in_if.value <= pend_q.pop_front();
        if (!calm && $urandom_range(0, 5) == 0) begin
          src_gap <= $urandom_range(1, 19);
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output sink: ready with random stall bursts, independent of valid.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      snk_gap      <= 0;
    end else if (snk_gap != 0) begin
      out_if.ready <= 1'b0;
      snk_gap      <= snk_gap - 1;
    end else begin
      out_if.ready <= 1'b1;
      if (!calm && $urandom_range(0, 5) == 0) begin
        snk_gap <= $urandom_range(1, 19);
      end
    end
  end

  // Monitor: the input beat is predicted before the output beat is checked,
  // so a result caused in the same cycle would already be queued.
  always @(posedge clk_i) begin : mon
    sorted_beat_t want;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        take_value(in_if.value);
      end
      if (out_if.valid && out_if.ready) begin
        if (sorted_q.size() == 0) begin
          miss_cnt++;
          $display("%0t: unexpected output beat, expected none, actual value %0d last %0b",
                   $time, out_if.sorted_value, out_if.last);
        end else begin
          want = sorted_q.pop_front();
          if (out_if.sorted_value !== want.sorted_value) begin
            miss_cnt++;
            $display("%0t: sorted_value wrong, expected %0d, actual %0d",
                     $time, want.sorted_value, out_if.sorted_value);
          end
          if (out_if.last !== want.last) begin
            miss_cnt++;
            $display("%0t: last wrong, expected %0b, actual %0b",
                     $time, want.last, out_if.last);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no beat and no register access completes.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      quiet_cnt <= 0;
    end else if (quiet_cnt == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("bitonic_sorter: mismatch");
      $finish;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
  end

  // APB write: setup, then access; the register takes the data at the edge
  // that closes the access phase.
  task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    // Only the size register exists; any write to it restarts the batch.
    if (addr == ADDR_SIZE_LOG2) begin
      size_cfg = data[SIZE_W-1:0];
      fill_cnt = 0;
    end
  endtask

  // APB read of the size register, compared with our copy.
  task automatic check_size_reg();
    logic [APB_DW-1:0] got;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_SIZE_LOG2;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[SIZE_W-1:0] !== size_cfg) begin
      miss_cnt++;
      $display("%0t: size_log2 readback wrong, expected %0d, actual %0d",
               $time, size_cfg, got[SIZE_W-1:0]);
    end
  endtask

  // Upper data bits are random; only the low bits belong to the register.
  task automatic set_size(input logic [SIZE_W-1:0] sz);
    logic [APB_DW-1:0] data;
    data             = $urandom;
    data[SIZE_W-1:0] = sz;
    apb_write(ADDR_SIZE_LOG2, data);
    check_size_reg();
  endtask

  task automatic queue_values(input int unsigned cnt);
    repeat (cnt) pend_q.push_back(pick_value());
  endtask

  // Block is idle once every value went in and every sorted beat came out;
  // checked on the falling edge to stay clear of the clocked processes.
  task automatic wait_idle();
    @(negedge clk_i);
    while (pend_q.size() != 0 || in_if.valid || sorted_q.size() != 0) @(negedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stim
    int unsigned       sent;
    int unsigned       batch_n;
    int unsigned       cnt;
    logic [SIZE_W-1:0] sz;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    size_cfg     = SIZE_RESET;
    fill_cnt     = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---- directed part ----
    check_size_reg();  // reset value

    // Size one: every value comes straight back with last set.
    set_size(0);
    pend_q.push_back(VAL_MAX);
    pend_q.push_back(VAL_MIN);
    pend_q.push_back(0);
    pend_q.push_back(-1);
    pend_q.push_back(1);
    wait_idle();

    // Four values: the extremes, then a batch with ties.
    set_size(2);
    pend_q.push_back(VAL_MAX);
    pend_q.push_back(VAL_MIN);
    pend_q.push_back(-1);
    pend_q.push_back(0);
    pend_q.push_back(5);
    pend_q.push_back(5);
    pend_q.push_back(-3);
    pend_q.push_back(5);
    wait_idle();

    // Size write in the middle of a batch drops what was loaded.
    set_size(3);
    pend_q.push_back(7);
    pend_q.push_back(-7);
    pend_q.push_back(100);
    wait_idle();
    set_size(1);
    pend_q.push_back(9);
    pend_q.push_back(-9);
    wait_idle();

    // A write past the register map must leave size and batch alone.
    pend_q.push_back(42);
    wait_idle();
    apb_write(ADDR_UNMAPPED, $urandom);
    check_size_reg();
    pend_q.push_back(-42);
    wait_idle();

    // ---- random part ----
    // Size above the maximum: one full-size batch.
    set_size(7);
    queue_values(STORE_N);
    wait_idle();
    // Maximum size written, then abandoned part way.
    set_size(6);
    queue_values(10);
    wait_idle();
    sent = STORE_N + 10;

    // Mostly small batches, sometimes with a partial batch left behind for
    // the next size write to discard.
    while (sent < RAND_ITEMS) begin
      sz      = ($urandom_range(0, 7) == 0) ? 3'd5 : SIZE_W'($urandom_range(0, 4));
      set_size(sz);
      batch_n = 1 << sz;
      cnt     = batch_n * $urandom_range(1, 3);
      if (batch_n > 1 && $urandom_range(0, 2) == 0) begin
        cnt += $urandom_range(1, batch_n - 1);
      end
      queue_values(cnt);
      sent += cnt;
      wait_idle();
      if ($urandom_range(0, 3) == 0) apb_write(ADDR_UNMAPPED, $urandom);
    end

    // Closing stretch: no idling on either side.
    calm = 1'b1;
    set_size(2);
    queue_values(8);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (miss_cnt == 0) begin
      $display("bitonic_sorter: match");
    end else begin
      $display("bitonic_sorter: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bs_pkg.sv
rtl/bs_in_if.sv
rtl/bs_out_if.sv
rtl/bs_datapath.sv
rtl/bs_ctrl.sv
rtl/bitonic_sorter.sv
tb/sv/tb_bitonic_sorter.sv
